// File: rtl/sorted_unique_set_insert_core_macros.svh
// Assertion macros for the sorted unique set insert core.
// Used by the top level only; expects clk_i and rst_ni in scope.
`ifndef SORTED_UNIQUE_SET_INSERT_CORE_MACROS_SVH
`define SORTED_UNIQUE_SET_INSERT_CORE_MACROS_SVH

// A condition that must hold at every clock edge outside reset.
`define SUS_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// A consequence that must hold in the cycle after the antecedent.
`define SUS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/sus_pkg.sv
// Shared types and constants for the sorted unique set insert core.
// No dependencies; used by sus_cell, sorted_unique_set_insert_core and the testbench.
package sus_pkg;

  // Field widths.
  localparam int unsigned KindW   = 2;
  localparam int unsigned ValueW  = 7;
  localparam int unsigned IndexW  = 4;
  localparam int unsigned StatusW = 3;
  localparam int unsigned CountW  = 5;

  // Default number of cells and the reset value of the range register.
  localparam int unsigned Capacity = 16;
  localparam logic [ValueW-1:0] MaxValueReset = 7'd80;

  // Request kinds.
  localparam logic [KindW-1:0] KindInsert = 2'd0;
  localparam logic [KindW-1:0] KindClear  = 2'd1;
  localparam logic [KindW-1:0] KindRead   = 2'd2;

  // Result status codes.
  localparam logic [StatusW-1:0] StDone  = 3'd0;
  localparam logic [StatusW-1:0] StDup   = 3'd1;
  localparam logic [StatusW-1:0] StRange = 3'd2;
  localparam logic [StatusW-1:0] StFull  = 3'd3;
  localparam logic [StatusW-1:0] StIndex = 3'd4;

  // Command broadcast to every cell.
  typedef struct packed {
    logic              insert;
    logic              clear;
    logic [ValueW-1:0] value;
  } cmd_t;

  // What one cell hands to its right-hand neighbor.
  typedef struct packed {
    logic [ValueW-1:0] value;
    logic              valid;
    logic              less;
  } link_t;

endpackage

// File: rtl/sorted_unique_set_insert_core.sv
// Sorted unique set core: a row of compare-and-shift cells keeps values ascending.
// The result strobe done_o rises in the cycle after a request is accepted.
// Throughput: one request per cycle; every cell compares and shifts in that cycle.
// busy_o stays low, since the receiver cannot stall and every request is handled by a single register update.
// Reset empties the set and loads max_value with 80; stored values are not cleared.
`include "sorted_unique_set_insert_core_macros.svh"

module sorted_unique_set_insert_core #(
  parameter int unsigned Capacity = sus_pkg::Capacity
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  output logic                        busy_o,
  input  logic [sus_pkg::KindW-1:0]   kind_i,
  input  logic [sus_pkg::ValueW-1:0]  value_i,
  input  logic [sus_pkg::IndexW-1:0]  index_i,
  input  logic                        cfg_we_i,
  input  logic [sus_pkg::ValueW-1:0]  cfg_wdata_i,
  output logic                        done_o,
  output logic [sus_pkg::StatusW-1:0] status_o,
  output logic [sus_pkg::CountW-1:0]  count_o,
  output logic [sus_pkg::ValueW-1:0]  entry_o
);

  localparam int unsigned CntW = $clog2(Capacity + 1);

  logic [sus_pkg::ValueW-1:0]  max_value_q;
  logic [CntW-1:0]             count_q, count_d;
  logic                        done_q;
  logic [sus_pkg::StatusW-1:0] status_q, status_d;
  logic [sus_pkg::ValueW-1:0]  entry_q, entry_d;

  sus_pkg::cmd_t               cmd;
  sus_pkg::link_t              links [Capacity+1];
  logic [Capacity-1:0]         match_vec;
  logic [Capacity-1:0]         hit_vec;
  logic [Capacity-1:0]         valid_vec;
  logic [sus_pkg::ValueW-1:0]  rd_vals [Capacity];
  logic [sus_pkg::ValueW-1:0]  rd_any;

  logic accept;
  logic in_range;
  logic dup;
  logic full;
  logic rd_hit;
  logic do_insert;

  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  // Insert decision: range test first, then duplicate, then room.
  assign in_range  = (value_i != '0) && (value_i <= max_value_q);
  assign dup       = |match_vec;
  assign full      = valid_vec[Capacity-1];
  assign rd_hit    = |hit_vec;
  assign do_insert = accept && (kind_i == sus_pkg::KindInsert) && in_range && !dup && !full;

  assign cmd = '{insert: do_insert,
                 clear:  accept && (kind_i == sus_pkg::KindClear),
                 value:  value_i};

  // The left edge of the row looks like a cell that is less than any value.
  assign links[0] = '{value: '0, valid: 1'b0, less: 1'b1};

  for (genvar i = 0; i < Capacity; i++) begin : g_cell
    sus_cell #(
      .Idx(i)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .cmd_i      (cmd),
      .index_i    (index_i),
      .link_i     (links[i]),
      .link_o     (links[i+1]),
      .match_o    (match_vec[i]),
      .rd_hit_o   (hit_vec[i]),
      .rd_value_o (rd_vals[i])
    );
    assign valid_vec[i] = links[i+1].valid;
  end

  // At most one cell drives a nonzero read value.
  always_comb begin
    rd_any = '0;
    for (int i = 0; i < Capacity; i++) begin
      rd_any = rd_any | rd_vals[i];
    end
  end

  // Result status and entry for the accepted request.
  always_comb begin
    status_d = sus_pkg::StDone;
    entry_d  = '0;
    case (kind_i)
      sus_pkg::KindInsert: begin
        if (!in_range) begin
          status_d = sus_pkg::StRange;
        end else if (dup) begin
          status_d = sus_pkg::StDup;
        end else if (full) begin
          status_d = sus_pkg::StFull;
        end
      end
      sus_pkg::KindClear: begin
        status_d = sus_pkg::StDone;
      end
      sus_pkg::KindRead: begin
        if (rd_hit) begin
          entry_d = rd_any;
        end else begin
          status_d = sus_pkg::StIndex;
        end
      end
      default: begin
        status_d = sus_pkg::StDone;
      end
    endcase
  end

  // Stored count, kept in step with the cells' valid bits: cleared on clear, incremented on insert.
  always_comb begin
    count_d = count_q;
    if (cmd.clear) begin
      count_d = '0;
    end else if (do_insert) begin
      count_d = count_q + CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_value_q <= sus_pkg::MaxValueReset;
      count_q     <= '0;
      done_q      <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        max_value_q <= cfg_wdata_i;
      end
      count_q <= count_d;
      done_q  <= accept;
    end
  end

  // Result payload registers.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q <= status_d;
      entry_q  <= entry_d;
    end
  end

  assign done_o   = done_q;
  assign status_o = status_q;
  assign entry_o  = entry_q;
  assign count_o  = sus_pkg::CountW'(count_q);

  // Every accepted request produces its result strobe in the next cycle.
  `SUS_ASSERT_NEXT(a_strobe_follows, accept, done_o, "result strobe missing after request")
  // The number of set valid bits of the cells equals the stored count.
  `SUS_ASSERT_ALWAYS(a_count_matches, $countones(valid_vec) == 32'(count_q),
                     "cell valid bits disagree with stored count")
  // A clear reports an empty set.
  `SUS_ASSERT_NEXT(a_clear_empties, accept && kind_i == sus_pkg::KindClear,
                   done_o && count_o == '0, "clear did not empty the set")

endmodule

// File: rtl/sus_cell.sv
// One compare-and-shift cell of the sorted set row.
// Depends on sus_pkg for the command and link types.
module sus_cell #(
  parameter int unsigned Idx = 0
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  sus_pkg::cmd_t              cmd_i,
  input  logic [sus_pkg::IndexW-1:0] index_i,
  input  sus_pkg::link_t             link_i,
  output sus_pkg::link_t             link_o,
  output logic                       match_o,
  output logic                       rd_hit_o,
  output logic [sus_pkg::ValueW-1:0] rd_value_o
);

  logic [sus_pkg::ValueW-1:0] value_q, value_d;
  logic                       valid_q, valid_d;
  logic                       less;
  logic                       sel;

  // Compare the stored value against the broadcast value.
  assign less    = valid_q && (value_q < cmd_i.value);
  assign match_o = valid_q && (value_q == cmd_i.value);

  // On insert, the cell at the insert point takes the new value and the cells after it take the value from the left.
  always_comb begin
    value_d = value_q;
    valid_d = valid_q;
    if (cmd_i.clear) begin
      valid_d = 1'b0;
    end else if (cmd_i.insert && !less) begin
      if (link_i.less) begin
        value_d = cmd_i.value;
        valid_d = 1'b1;
      end else begin
        value_d = link_i.value;
        valid_d = link_i.valid;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  // Read port: this cell answers when the request index names its position.
  assign sel        = (32'(index_i) == 32'(Idx));
  assign rd_hit_o   = valid_q && sel;
  assign rd_value_o = rd_hit_o ? value_q : '0;

  assign link_o = '{value: value_q, valid: valid_q, less: less};

endmodule

// File: dv/testbench.sv
// Self-checking testbench for sorted_unique_set_insert_core: directed and random requests.
// Depends on sus_pkg and the core RTL; a scoreboard class keeps its own copy of the set.
`timescale 1ns / 1ps

module testbench;
  import sus_pkg::*;

  // The kind code that the core ignores; the package names only the three used ones.
  localparam logic [KindW-1:0] KindUnused = 2'd3;
  localparam int unsigned WatchdogLimit = 1000;
  localparam int unsigned MaxReports = 10;
  localparam int unsigned NumPhases = 8;
  localparam int unsigned PhaseRequests = 205;

  typedef struct packed {
    logic [StatusW-1:0] status;
    logic [CountW-1:0]  count;
    logic [ValueW-1:0]  entry;
  } set_result_t;

  // Tracks the set contents and the range limit, and compares results in order.
  class set_scoreboard;
    logic [ValueW-1:0] members [Capacity];
    int unsigned       member_count;
    logic [ValueW-1:0] max_value;
    set_result_t       expected_q [$];
    int unsigned       results_checked;
    int unsigned       failures;
    int unsigned       status_hits [5];

    function new();
      max_value = MaxValueReset;
      member_count = 0;
      results_checked = 0;
      failures = 0;
      foreach (members[i]) members[i] = '0;
      foreach (status_hits[i]) status_hits[i] = 0;
    endfunction

    // Range test first, then duplicate, then room; the new value goes into its sorted slot.
    function logic [StatusW-1:0] insert_value(logic [ValueW-1:0] value);
      int pos;
      pos = 0;
      if (value == 0 || value > max_value) return StRange;
      while (pos < member_count && members[pos] < value) pos++;
      if (pos < member_count && members[pos] == value) return StDup;
      if (member_count >= Capacity) return StFull;
      for (int k = member_count; k > pos; k--) members[k] = members[k - 1];
      members[pos] = value;
      member_count++;
      return StDone;
    endfunction

    // Applies an accepted request to the set and queues the result it must produce.
    function void note_request(logic [KindW-1:0] kind, logic [ValueW-1:0] value,
                               logic [IndexW-1:0] index);
      set_result_t predicted;
      predicted.status = StDone;
      predicted.entry = '0;
      case (kind)
        KindInsert: predicted.status = insert_value(value);
        KindClear: member_count = 0;
        KindRead: begin
          if (index < member_count) predicted.entry = members[index];
          else predicted.status = StIndex;
        end
        default: ;
      endcase
      predicted.count = CountW'(member_count);
      expected_q.insert(expected_q.size(), predicted);
    endfunction

    // Compares one result with the oldest queued prediction.
    function void check_result(set_result_t got);
      set_result_t want;
      if (expected_q.size() == 0) begin
        failures++;
        if (failures <= MaxReports)
          $display("ERROR: result with no request pending: status %0d count %0d entry %0d",
                   got.status, got.count, got.entry);
        return;
      end
      want = expected_q.pop_front();
      results_checked++;
      if (want.status <= StIndex) status_hits[want.status]++;
      if (got.status !== want.status || got.count !== want.count ||
          got.entry !== want.entry) begin
        failures++;
        if (failures <= MaxReports)
          $display("ERROR: result %0d: expected status %0d count %0d entry %0d, got %0d %0d %0d",
                   results_checked, want.status, want.count, want.entry,
                   got.status, got.count, got.entry);
      end
    endfunction
  endclass

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               start_i = 1'b0;
  logic [KindW-1:0]   kind_i = KindRead;
  logic [ValueW-1:0]  value_i = '0;
  logic [IndexW-1:0]  index_i = '0;
  logic               cfg_we_i = 1'b0;
  logic [ValueW-1:0]  cfg_wdata_i = '0;
  logic               busy_o;
  logic               done_o;
  logic [StatusW-1:0] status_o;
  logic [CountW-1:0]  count_o;
  logic [ValueW-1:0]  entry_o;

  set_scoreboard sb = new();
  int unsigned   quiet_cycles = 0;
  int unsigned   requests_accepted = 0;
  bit            steady_flow = 1'b0;

  always #5 clk_i = ~clk_i;

  sorted_unique_set_insert_core u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .busy_o      (busy_o),
    .kind_i      (kind_i),
    .value_i     (value_i),
    .index_i     (index_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .done_o      (done_o),
    .status_o    (status_o),
    .count_o     (count_o),
    .entry_o     (entry_o)
  );

  // Samples at the rising edge: register writes, accepted requests, results, and the watchdog.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_we_i) sb.max_value = cfg_wdata_i;
      if (start_i && !busy_o) begin
        sb.note_request(kind_i, value_i, index_i);
        requests_accepted++;
      end
      if (done_o) sb.check_result('{status_o, count_o, entry_o});
      if (cfg_we_i || (start_i && !busy_o) || done_o) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WatchdogLimit) begin
        $display("Watchdog: nothing accepted for %0d cycles", WatchdogLimit);
        $display("FAILURE");
        $finish;
      end
    end
  end

  // Mostly values inside the current range, with zero and arbitrary values mixed in.
  function automatic logic [ValueW-1:0] pick_value();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 80 && sb.max_value != 0) return ValueW'($urandom_range(sb.max_value, 1));
    if (roll < 88) return '0;
    return ValueW'($urandom_range(127, 0));
  endfunction

  // Drives one request after a random gap and holds it until the core takes it.
  // Random fields are chosen at the falling edge, after the last request is accounted for.
  task automatic issue_request(input bit pick_fields, input logic [KindW-1:0] kind,
                               input logic [ValueW-1:0] value,
                               input logic [IndexW-1:0] index);
    while (!steady_flow && $urandom_range(99) < 35) begin
      @(negedge clk_i);
      start_i <= 1'b0;
      kind_i <= KindW'($urandom);
      value_i <= ValueW'($urandom);
      index_i <= IndexW'($urandom);
    end
    @(negedge clk_i);
    if (pick_fields) begin
      value = pick_value();
      if (sb.member_count != 0 && $urandom_range(1) == 1)
        index = IndexW'($urandom_range(sb.member_count - 1, 0));
      else
        index = IndexW'($urandom_range(15, 0));
    end
    start_i <= 1'b1;
    kind_i <= kind;
    value_i <= value;
    index_i <= index;
    do @(posedge clk_i); while (busy_o !== 1'b0);
  endtask

  // Stops sending and waits until every predicted result has come back.
  task automatic drain_results();
    @(negedge clk_i);
    start_i <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic write_max_value(input logic [ValueW-1:0] limit);
    drain_results();
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= limit;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    cfg_wdata_i <= ValueW'($urandom);
  endtask

  initial begin
    logic [ValueW-1:0] phase_limits [NumPhases];
    logic [KindW-1:0]  kind;
    int unsigned       roll;
    int unsigned       sent;

    phase_limits[0] = 7'd127;
    phase_limits[1] = 7'd0;
    phase_limits[2] = 7'd1;
    phase_limits[3] = 7'd16;
    phase_limits[4] = 7'd127;
    phase_limits[5] = ValueW'($urandom_range(126, 2));
    phase_limits[6] = ValueW'($urandom_range(126, 2));
    phase_limits[7] = MaxValueReset;

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed requests under the reset limit of 80.
    issue_request(1'b0, KindRead, 7'd0, 4'd0);      // read from an empty set
    issue_request(1'b0, KindInsert, 7'd0, 4'd0);    // zero is never in range
    issue_request(1'b0, KindInsert, 7'd81, 4'd0);   // just above the limit
    issue_request(1'b0, KindInsert, 7'd80, 4'd0);   // the limit itself
    issue_request(1'b0, KindInsert, 7'd1, 4'd0);
    issue_request(1'b0, KindInsert, 7'd80, 4'd0);   // duplicate
    issue_request(1'b0, KindUnused, 7'd127, 4'd15); // unused kind is ignored
    issue_request(1'b0, KindRead, 7'd0, 4'd0);
    issue_request(1'b0, KindRead, 7'd0, 4'd2);      // index equal to the count
    for (int v = 2; v <= 15; v++) issue_request(1'b0, KindInsert, ValueW'(v), 4'd0);
    issue_request(1'b0, KindInsert, 7'd50, 4'd0);   // set is full
    issue_request(1'b0, KindInsert, 7'd15, 4'd0);   // duplicate wins over full
    issue_request(1'b0, KindRead, 7'd0, 4'd15);     // last slot
    issue_request(1'b0, KindClear, 7'd0, 4'd0);
    issue_request(1'b0, KindRead, 7'd0, 4'd0);      // read after clear

    // Random phases, one per range limit; one phase runs with no gaps at all.
    for (int p = 0; p < NumPhases; p++) begin
      write_max_value(phase_limits[p]);
      steady_flow = (p == 4);
      sent = 0;
      while (sent < PhaseRequests) begin
        roll = $urandom_range(99);
        if (roll < 60) kind = KindInsert;
        else if (roll < 94) kind = KindRead;
        else if (roll < 97) kind = KindClear;
        else kind = KindUnused;
        issue_request(1'b1, kind, '0, '0);
        if (kind != KindUnused) sent++;
      end
    end
    steady_flow = 1'b0;
    drain_results();

    $display("Checked %0d results from %0d requests across %0d range limits.",
             sb.results_checked, requests_accepted, NumPhases);
    $display("Status mix: %0d done, %0d duplicate, %0d out of range, %0d full, %0d bad index.",
             sb.status_hits[0], sb.status_hits[1], sb.status_hits[2],
             sb.status_hits[3], sb.status_hits[4]);
    if (sb.expected_q.size() != 0)
      $display("ERROR: %0d predicted results never arrived", sb.expected_q.size());
    if (sb.failures == 0 && sb.expected_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+rtl
rtl/sus_pkg.sv
rtl/sus_cell.sv
rtl/sorted_unique_set_insert_core.sv
dv/testbench.sv
